/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, masked during reset
`define CMFS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cmfs_pkg.sv */
`timescale 1ns / 1ps

package cmfs_pkg;

	localparam int MAX_EDGE    = 64;
	localparam int EDGE_W      = $clog2(MAX_EDGE);
	localparam int FACE_COUNT  = 6;
	localparam int FACE_W      = 3;
	localparam int SIZE_W      = 7;
	localparam int STORE_DEPTH = FACE_COUNT * MAX_EDGE * MAX_EDGE;
	localparam int ADDR_W      = FACE_W + 2 * EDGE_W;
	localparam int DIR_W       = 16;
	localparam int CH_W        = 16;
	localparam int OUT_CH_W    = 15;
	// quotient never exceeds the face size, so it needs SIZE_W bits
	localparam int QUO_W       = SIZE_W;
	localparam int SUM_W       = DIR_W + 1;
	localparam int REM_W       = SUM_W + QUO_W - 1;
	localparam int BIT_W       = $clog2(QUO_W);

	localparam logic [SIZE_W-1:0] FACE_SIZE_RST = SIZE_W'(MAX_EDGE);

	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic REG_FACE_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_READ,
		ST_OUT
	} state_t;

	function automatic logic [OUT_CH_W-1:0] floor_zero(input logic [CH_W-1:0] raw);
		floor_zero = raw[CH_W-1] ? '0 : raw[OUT_CH_W-1:0];
	endfunction

endpackage

/* rtl/core/cube_map_face_sampler.sv */
`timescale 1ns / 1ps
// Cube-map sampler, nearest texel.
// Input: an item is taken at a clock edge with start high and busy low.
//   op = write: the texel wr_red/green/blue is stored at wr_face/wr_row/wr_col
//     in that same edge; busy stays low, so the next item may follow at once.
//     Writes to a face above 5 are dropped.
//   op = sample: dir_x/y/z picks the face by largest magnitude (ties to X, then
//     Y, then Z), and each face coordinate is turned into a texel index.
// Result: one per sample, on the result ports for one cycle with done high.
//   The receiver cannot stall; nothing is held back.
// Sequence: a sample runs a multiply step and a column division, a multiply
//   step and a row division, and a texel RAM read, then strobes done; busy
//   stays high until then, so the next item is taken only after done. The two
//   index divisions share one restoring divider at one quotient bit a cycle (7 bits each).
//   A zero direction strobes done with invalid high in the next cycle.
// Config: face_size at APB address 0, written by the user only while the block
//   is idle; the block does not enforce this. 0 acts as 1, above 64 as 64. Reset sets it to 64.
// Reset: arst_n clears the sequencer and face_size; the texel store is not
//   cleared and must be written before it is sampled.
`include "assert_macros.svh"

module cube_map_face_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic signed [cmfs_pkg::DIR_W-1:0]   dir_x,
	input  logic signed [cmfs_pkg::DIR_W-1:0]   dir_y,
	input  logic signed [cmfs_pkg::DIR_W-1:0]   dir_z,
	input  logic [cmfs_pkg::FACE_W-1:0]         wr_face,
	input  logic [cmfs_pkg::EDGE_W-1:0]         wr_col,
	input  logic [cmfs_pkg::EDGE_W-1:0]         wr_row,
	input  logic signed [cmfs_pkg::CH_W-1:0]    wr_red,
	input  logic signed [cmfs_pkg::CH_W-1:0]    wr_green,
	input  logic signed [cmfs_pkg::CH_W-1:0]    wr_blue,
	output logic                                done,
	output logic [cmfs_pkg::FACE_W-1:0]         face,
	output logic [cmfs_pkg::EDGE_W-1:0]         texel_col,
	output logic [cmfs_pkg::EDGE_W-1:0]         texel_row,
	output logic [cmfs_pkg::OUT_CH_W-1:0]       red,
	output logic [cmfs_pkg::OUT_CH_W-1:0]       green,
	output logic [cmfs_pkg::OUT_CH_W-1:0]       blue,
	output logic                                invalid,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int SW = cmfs_pkg::SUM_W;
	localparam int RW = cmfs_pkg::REM_W;
	localparam int QW = cmfs_pkg::QUO_W;
	localparam int EW = cmfs_pkg::EDGE_W;
	localparam int ZW = cmfs_pkg::SIZE_W;

	cmfs_pkg::state_t state_q, state_d;

	logic [ZW-1:0] face_size_q;
	logic [ZW-1:0] size_eff;

	logic accept;
	logic wr_en;
	logic smp_go;
	logic dir_zero;

	// face selection, evaluated on the accepting edge
	logic [cmfs_pkg::DIR_W-1:0] ax, ay, az;
	logic signed [SW-1:0] sx, sy, sz;
	logic [cmfs_pkg::FACE_W-1:0] sel_face;
	logic [cmfs_pkg::DIR_W-1:0]  sel_m;
	logic signed [SW-1:0] sel_cu, sel_cv;

	// datapath registers
	logic [cmfs_pkg::FACE_W-1:0] face_q;
	logic [cmfs_pkg::DIR_W-1:0]  m_q;
	logic signed [SW-1:0] cu_q, cv_q;
	logic [ZW-1:0] s_q;
	logic          inv_q;
	logic          axis_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [cmfs_pkg::BIT_W-1:0] bit_q;
	logic [EW-1:0] col_q, row_q;

	// shared unit signals
	logic signed [SW:0] coord_sum;
	logic [SW-1:0]      num_base;
	logic [RW-1:0]      product;
	logic [RW-1:0]      den_shift;
	logic               fits;
	logic [QW-1:0]      quo_next;
	logic [EW-1:0]      idx_clamped;
	logic               div_last;

	// texel store
	logic [3*cmfs_pkg::CH_W-1:0] store_mem [cmfs_pkg::STORE_DEPTH];
	logic [3*cmfs_pkg::CH_W-1:0] rd_q;
	logic [cmfs_pkg::ADDR_W-1:0] wr_addr, rd_addr;

	assign accept   = start && !busy;
	assign dir_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
	assign wr_en    = accept && (op == cmfs_pkg::OP_WRITE) &&
		(wr_face < cmfs_pkg::FACE_W'(cmfs_pkg::FACE_COUNT));
	assign smp_go   = accept && (op == cmfs_pkg::OP_SAMPLE);

	assign size_eff = (face_size_q == '0) ? ZW'(1) :
		(face_size_q > cmfs_pkg::FACE_SIZE_RST) ? cmfs_pkg::FACE_SIZE_RST : face_size_q;

	// --- configuration port ---
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cmfs_pkg::REG_FACE_SIZE) ? {{(32-ZW){1'b0}}, face_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= cmfs_pkg::FACE_SIZE_RST;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == cmfs_pkg::REG_FACE_SIZE) begin
			face_size_q <= pwdata[ZW-1:0];
		end
	end

	// --- face select ---
	always_comb begin
		sx = {dir_x[cmfs_pkg::DIR_W-1], dir_x};
		sy = {dir_y[cmfs_pkg::DIR_W-1], dir_y};
		sz = {dir_z[cmfs_pkg::DIR_W-1], dir_z};
		ax = dir_x[cmfs_pkg::DIR_W-1] ? cmfs_pkg::DIR_W'(-dir_x) : dir_x;
		ay = dir_y[cmfs_pkg::DIR_W-1] ? cmfs_pkg::DIR_W'(-dir_y) : dir_y;
		az = dir_z[cmfs_pkg::DIR_W-1] ? cmfs_pkg::DIR_W'(-dir_z) : dir_z;
		if (ax >= ay && ax >= az) begin
			sel_m  = ax;
			sel_cv = -sy;
			if (!dir_x[cmfs_pkg::DIR_W-1]) begin
				sel_face = cmfs_pkg::FACE_POS_X;
				sel_cu   = -sz;
			end else begin
				sel_face = cmfs_pkg::FACE_NEG_X;
				sel_cu   = sz;
			end
		end else if (ay >= ax && ay >= az) begin
			sel_m  = ay;
			sel_cu = sx;
			if (!dir_y[cmfs_pkg::DIR_W-1]) begin
				sel_face = cmfs_pkg::FACE_POS_Y;
				sel_cv   = sz;
			end else begin
				sel_face = cmfs_pkg::FACE_NEG_Y;
				sel_cv   = -sz;
			end
		end else begin
			sel_m  = az;
			sel_cv = -sy;
			if (!dir_z[cmfs_pkg::DIR_W-1]) begin
				sel_face = cmfs_pkg::FACE_POS_Z;
				sel_cu   = sx;
			end else begin
				sel_face = cmfs_pkg::FACE_NEG_Z;
				sel_cu   = -sx;
			end
		end
	end

	// --- shared multiply / restoring divide ---
	// (c + m) lies in 0..2m, so the sum is never negative
	assign coord_sum = (axis_q ? {cv_q[SW-1], cv_q} : {cu_q[SW-1], cu_q}) +
		$signed({2'b00, m_q});
	assign num_base  = coord_sum[SW-1:0];
	assign product   = RW'(num_base * s_q);
	assign den_shift = RW'({m_q, 1'b0}) << bit_q;
	assign fits      = (rem_q >= den_shift);
	assign quo_next  = quo_q | (QW'(fits) << bit_q);
	assign div_last  = (bit_q == '0);
	assign idx_clamped = (quo_next >= s_q) ? EW'(s_q - ZW'(1)) : quo_next[EW-1:0];

	// --- sequencer ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			cmfs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (smp_go) begin
					state_d = dir_zero ? cmfs_pkg::ST_OUT : cmfs_pkg::ST_MUL;
				end
			end
			cmfs_pkg::ST_MUL: begin
				state_d = cmfs_pkg::ST_DIV;
			end
			cmfs_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = axis_q ? cmfs_pkg::ST_READ : cmfs_pkg::ST_MUL;
				end
			end
			cmfs_pkg::ST_READ: begin
				state_d = cmfs_pkg::ST_OUT;
			end
			cmfs_pkg::ST_OUT: begin
				done    = 1'b1;
				state_d = cmfs_pkg::ST_IDLE;
			end
			default: begin
				state_d = cmfs_pkg::ST_IDLE;
			end
		endcase
	end

	// --- datapath ---
	always_ff @(posedge clk) begin
		case (state_q)
			cmfs_pkg::ST_IDLE: begin
				if (smp_go) begin
					face_q <= dir_zero ? '0 : sel_face;
					m_q    <= sel_m;
					cu_q   <= sel_cu;
					cv_q   <= sel_cv;
					s_q    <= size_eff;
					inv_q  <= dir_zero;
					axis_q <= 1'b0;
					col_q  <= '0;
					row_q  <= '0;
				end
			end
			cmfs_pkg::ST_MUL: begin
				rem_q <= product;
				quo_q <= '0;
				bit_q <= cmfs_pkg::BIT_W'(QW - 1);
			end
			cmfs_pkg::ST_DIV: begin
				if (fits) begin
					rem_q <= rem_q - den_shift;
				end
				quo_q <= quo_next;
				if (div_last) begin
					if (axis_q) begin
						row_q <= idx_clamped;
					end else begin
						col_q <= idx_clamped;
					end
					axis_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// --- texel store: one write port, one registered read port ---
	assign wr_addr = {wr_face, wr_row, wr_col};
	assign rd_addr = {face_q, row_q, col_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= {wr_red, wr_green, wr_blue};
		end
		if (state_q == cmfs_pkg::ST_READ) begin
			rd_q <= store_mem[rd_addr];
		end
	end

	// --- result ---
	assign face      = face_q;
	assign texel_col = col_q;
	assign texel_row = row_q;
	assign invalid   = inv_q;
	assign red   = inv_q ? '0 : cmfs_pkg::floor_zero(rd_q[3*cmfs_pkg::CH_W-1:2*cmfs_pkg::CH_W]);
	assign green = inv_q ? '0 : cmfs_pkg::floor_zero(rd_q[2*cmfs_pkg::CH_W-1:cmfs_pkg::CH_W]);
	assign blue  = inv_q ? '0 : cmfs_pkg::floor_zero(rd_q[cmfs_pkg::CH_W-1:0]);

	// --- assertions ---
	`CMFS_ASSERT_NEXT(a_sample_holds_busy, smp_go, busy, "sample transaction did not raise busy")
	`CMFS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`CMFS_ASSERT(a_col_in_face, done && !invalid, ({1'b0, texel_col} < s_q), "column beyond face size")
	`CMFS_ASSERT(a_row_in_face, done && !invalid, ({1'b0, texel_row} < s_q), "row beyond face size")

endmodule
